>>> design/button_tap_hold_dimmer_fsm_macros.svh
// assertion macros shared by the button dimmer modules
// used by bthd_lane and bthd_merge; needs nothing else
`ifndef BUTTON_TAP_HOLD_DIMMER_FSM_MACROS_SVH
`define BUTTON_TAP_HOLD_DIMMER_FSM_MACROS_SVH

// same-cycle implication
`define BTHD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bthd same-cycle check failed");

// next-cycle implication
`define BTHD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bthd next-cycle check failed");

`endif

>>> design/bthd_pkg.sv
// shared types, constants and helpers for the button tap/hold dimmer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bthd_pkg;

  localparam int CNT_W           = 8;
  localparam int PIN_W           = 5;
  localparam int NUM_BUTTONS_DEF = 5;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd1;
  localparam logic [CNT_W-1:0] HOLD_RST     = 8'd50;
  localparam logic [CNT_W-1:0] REPEAT_RST   = 8'd25;
  localparam logic [CNT_W-1:0] WINDOW_RST   = 8'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_WINDOW   = 2'd3
  } reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] settle_ticks;
    logic [CNT_W-1:0] hold_start_ticks;
    logic [CNT_W-1:0] repeat_ticks;
    logic [CNT_W-1:0] repress_window_ticks;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [PIN_W-1:0] pins;
  } in_t;

  typedef struct packed {
    logic [PIN_W-1:0] toggle_mask;
    logic [PIN_W-1:0] fade_step_mask;
    logic [PIN_W-1:0] fade_down_mask;
    logic             all_idle;
  } out_t;

  typedef struct packed {
    logic toggle;
    logic step;
    logic down;
    logic idle;
  } lane_res_t;

  // a zero load counts as one tick
  function automatic logic [CNT_W-1:0] load_of(input logic [CNT_W-1:0] val);
    load_of = (val == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : val;
  endfunction

endpackage

`default_nettype wire

>>> design/button_tap_hold_dimmer_fsm.sv
// Tap / hold / repress dimmer front end for up to five active-low buttons. Each transfer
// on the input channel is either a pin sample (op 0) or a 10 ms tick (op 1) and yields
// exactly one result transfer. All button lanes update in parallel in the cycle the item
// is taken, so a new item is accepted every clock while not stalled; the result is
// registered in the output stage, whose two entries let up to two results wait while the
// output is stalled; the input stalls only when both entries are occupied. The user must
// write configuration registers through cfg_we / cfg_index / cfg_data only while no item
// is in flight (the block does not check). depends on bthd_pkg, bthd_lane and bthd_merge
`timescale 1ns / 1ps
`default_nettype none

module button_tap_hold_dimmer_fsm #(
  parameter int NUM_BUTTONS = bthd_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire bthd_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output bthd_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [bthd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bthd_pkg::CNT_W-1:0]     cfg_data
);

  bthd_pkg::cfg_t              cfg;
  logic [bthd_pkg::PIN_W-1:0]  last_pins;
  logic [bthd_pkg::PIN_W-1:0]  changed;
  logic                        accept;
  logic                        full;
  logic [NUM_BUTTONS-1:0]      lane_pin_chg;
  logic [NUM_BUTTONS-1:0]      lane_pin_level;
  bthd_pkg::lane_res_t         lane_res [NUM_BUTTONS];

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;
  assign changed  = in_data.pins ^ last_pins;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks         <= bthd_pkg::DEBOUNCE_RST;
      cfg.hold_start_ticks     <= bthd_pkg::HOLD_RST;
      cfg.repeat_ticks         <= bthd_pkg::REPEAT_RST;
      cfg.repress_window_ticks <= bthd_pkg::WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bthd_pkg::REG_DEBOUNCE: cfg.settle_ticks         <= cfg_data;
        bthd_pkg::REG_HOLD:     cfg.hold_start_ticks     <= cfg_data;
        bthd_pkg::REG_REPEAT:   cfg.repeat_ticks         <= cfg_data;
        bthd_pkg::REG_WINDOW:   cfg.repress_window_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pins <= '1;
    end else if (accept && !in_data.op) begin
      last_pins <= in_data.pins;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < bthd_pkg::PIN_W) begin : g_pin
      assign lane_pin_chg[i]   = changed[i];
      assign lane_pin_level[i] = in_data.pins[i];
    end else begin : g_nopin
      assign lane_pin_chg[i]   = 1'b0;
      assign lane_pin_level[i] = 1'b1;
    end

    bthd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .op        (in_data.op),
      .pin_chg   (lane_pin_chg[i]),
      .pin_level (lane_pin_level[i]),
      .cfg       (cfg),
      .res       (lane_res[i])
    );
  end

  bthd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .lane_res  (lane_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> design/bthd_lane.sv
// one button lane: debounce / hold / repress state machine with countdown timer
// depends on bthd_pkg and button_tap_hold_dimmer_fsm_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "button_tap_hold_dimmer_fsm_macros.svh"

module bthd_lane (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              op,
  input  wire logic              pin_chg,
  input  wire logic              pin_level,
  input  wire bthd_pkg::cfg_t    cfg,
  output bthd_pkg::lane_res_t    res
);

  typedef enum logic [5:0] {
    PH_RELEASED     = 6'b000001,
    PH_PRESS_DB     = 6'b000010,
    PH_PRESSED      = 6'b000100,
    PH_RELEASE_DB   = 6'b001000,
    PH_REPRESS_DB   = 6'b010000,
    PH_WAIT_REPRESS = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  phase_t                       phase, phase_next;
  dir_t                         dir, dir_next;
  logic                         pin_rel, pin_rel_next;
  logic [bthd_pkg::CNT_W-1:0]   countdown, countdown_next;
  logic [bthd_pkg::CNT_W-1:0]   cd_dec;
  logic                         ev_press, ev_release, ev_timer;
  dir_t                         dir_hold;

  always_comb begin
    phase_next     = phase;
    dir_next       = dir;
    pin_rel_next   = pin_rel;
    countdown_next = countdown;
    ev_press       = 1'b0;
    ev_release     = 1'b0;
    ev_timer       = 1'b0;
    res            = '0;
    cd_dec         = countdown - {{(bthd_pkg::CNT_W-1){1'b0}}, 1'b1};
    dir_hold       = (dir == DIR_NONE) ? DIR_DOWN : dir;

    if (!op) begin
      if (pin_chg) begin
        pin_rel_next = pin_level;
        ev_press     = !pin_level;
        ev_release   = pin_level;
      end
    end else if (countdown != '0) begin
      countdown_next = cd_dec;
      ev_timer       = (cd_dec == '0);
    end

    case (phase)
      PH_PRESS_DB: begin
        if (ev_timer) begin
          if (pin_rel_next) begin
            phase_next     = PH_RELEASED;
            countdown_next = '0;
          end else begin
            phase_next     = PH_PRESSED;
            countdown_next = bthd_pkg::load_of(cfg.hold_start_ticks);
          end
        end
      end
      PH_PRESSED: begin
        if (ev_release) begin
          phase_next     = PH_RELEASE_DB;
          countdown_next = bthd_pkg::load_of(cfg.settle_ticks);
        end else if (ev_timer) begin
          dir_next       = dir_hold;
          res.step       = 1'b1;
          res.down       = (dir_hold == DIR_DOWN);
          countdown_next = bthd_pkg::load_of(cfg.repeat_ticks);
        end
      end
      PH_RELEASE_DB: begin
        if (ev_timer) begin
          if (pin_rel_next) begin
            if (dir == DIR_NONE) begin
              res.toggle     = 1'b1;
              phase_next     = PH_RELEASED;
              countdown_next = '0;
            end else begin
              phase_next     = PH_WAIT_REPRESS;
              countdown_next = bthd_pkg::load_of(cfg.repress_window_ticks);
            end
          end else begin
            phase_next = PH_PRESSED;
          end
        end
      end
      PH_REPRESS_DB: begin
        if (ev_timer) begin
          if (pin_rel_next) begin
            phase_next     = PH_RELEASED;
            countdown_next = '0;
          end else begin
            dir_next       = (dir == DIR_DOWN) ? DIR_UP : DIR_DOWN;
            phase_next     = PH_PRESSED;
            countdown_next = bthd_pkg::load_of(cfg.repeat_ticks);
          end
        end
      end
      PH_WAIT_REPRESS: begin
        if (ev_timer) begin
          phase_next = PH_RELEASED;
          dir_next   = DIR_NONE;
        end else if (ev_press) begin
          phase_next     = PH_REPRESS_DB;
          countdown_next = bthd_pkg::load_of(cfg.settle_ticks);
        end
      end
      default: begin
        if (ev_press) begin
          phase_next     = PH_PRESS_DB;
          countdown_next = bthd_pkg::load_of(cfg.settle_ticks);
        end
      end
    endcase

    res.idle = (phase_next == PH_RELEASED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RELEASED;
      dir       <= DIR_NONE;
      pin_rel   <= 1'b1;
      countdown <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      dir       <= dir_next;
      pin_rel   <= pin_rel_next;
      countdown <= countdown_next;
    end
  end

  `BTHD_ASSERT_IMP(a_released_timer_idle, clk, rst, phase == PH_RELEASED, countdown == '0)
  `BTHD_ASSERT_NXT(a_step_rearms, clk, rst, accept && res.step, phase == PH_PRESSED && countdown != '0)
  `BTHD_ASSERT_NXT(a_toggle_releases, clk, rst, accept && res.toggle, phase == PH_RELEASED && dir == DIR_NONE)

endmodule

`default_nettype wire

>>> design/bthd_merge.sv
// merges lane results into one result word and holds it in a two-entry output stage
// depends on bthd_pkg and button_tap_hold_dimmer_fsm_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "button_tap_hold_dimmer_fsm_macros.svh"

module bthd_merge #(
  parameter int NUM_BUTTONS = bthd_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bthd_pkg::lane_res_t lane_res [NUM_BUTTONS],
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bthd_pkg::out_t           out_data
);

  bthd_pkg::out_t          merged;
  bthd_pkg::out_t          skid;
  logic                    skid_valid;
  logic                    out_fire;
  logic [NUM_BUTTONS-1:0]  idle_bits;

  for (genvar i = 0; i < bthd_pkg::PIN_W; i++) begin : g_mask
    if (i < NUM_BUTTONS) begin : g_lane
      assign merged.toggle_mask[i]    = lane_res[i].toggle;
      assign merged.fade_step_mask[i] = lane_res[i].step;
      assign merged.fade_down_mask[i] = lane_res[i].down;
    end else begin : g_none
      assign merged.toggle_mask[i]    = 1'b0;
      assign merged.fade_step_mask[i] = 1'b0;
      assign merged.fade_down_mask[i] = 1'b0;
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_idle
    assign idle_bits[i] = lane_res[i].idle;
  end

  assign merged.all_idle = &idle_bits;
  assign out_fire        = out_valid && !out_stall;
  assign full            = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || out_fire) begin
        out_data <= merged;
      end else begin
        skid <= merged;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid;
    end
  end

  `BTHD_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `BTHD_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !skid_valid)
  `BTHD_ASSERT_NXT(a_skid_drains, clk, rst, out_fire && skid_valid && !push, out_valid && !skid_valid)

endmodule

`default_nettype wire

>>> tb/sv/tb_button_tap_hold_dimmer_fsm.sv
// self-checking testbench for button_tap_hold_dimmer_fsm: directed tap, hold, repress and
// bounce sequences, timing extremes, random button activity and output backpressure
// depends on bthd_pkg and the button_tap_hold_dimmer_fsm rtl
`timescale 1ns / 1ps

module tb_button_tap_hold_dimmer_fsm;

  localparam int NB              = bthd_pkg::NUM_BUTTONS_DEF;
  localparam int CW              = bthd_pkg::CNT_W;
  localparam int PW              = bthd_pkg::PIN_W;
  localparam int IDLE_PCT        = 12;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int SETTLE_CYCLES   = 4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_RELEASED     = 3'd0,
    ST_PRESS_DB     = 3'd1,
    ST_PRESSED      = 3'd2,
    ST_RELEASE_DB   = 3'd3,
    ST_REPRESS_DB   = 3'd4,
    ST_WAIT_REPRESS = 3'd5
  } lane_state_e;

  typedef enum logic [1:0] {
    DIR_OFF  = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } fade_dir_e;

  typedef enum logic [1:0] {
    EVT_PRESS,
    EVT_RELEASE,
    EVT_TIMER
  } lane_evt_e;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  bthd_pkg::in_t                  in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  bthd_pkg::out_t                 out_data;
  logic                           cfg_we    = 1'b0;
  logic [bthd_pkg::CFG_IDX_W-1:0] cfg_index = bthd_pkg::REG_DEBOUNCE;
  logic [CW-1:0]                  cfg_data  = '0;

  int             idle_pct     = IDLE_PCT;
  logic           hold_out_req = 1'b0;
  int             error_count  = 0;
  bthd_pkg::out_t pending_reports [$];
  bthd_pkg::out_t want_report;

  // dimmer state mirror
  bthd_pkg::cfg_t timing;
  lane_state_e    lane_state [NB];
  logic           pin_up     [NB];
  fade_dir_e      lane_dir   [NB];
  logic [CW-1:0]  lane_timer [NB];
  logic [PW-1:0]  prev_pins;
  bthd_pkg::out_t step_report;

  button_tap_hold_dimmer_fsm #(.NUM_BUTTONS(NB)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [CW-1:0] at_least_one(input logic [CW-1:0] v);
    return (v == '0) ? CW'(1) : v;
  endfunction

  function automatic void enter_state(input int l, input lane_state_e s,
                                      input logic [CW-1:0] load);
    lane_state[l] = s;
    lane_timer[l] = load;
  endfunction

  function automatic void lane_event(input int l, input lane_evt_e ev);
    case (lane_state[l])
      ST_PRESS_DB: begin
        if (ev == EVT_TIMER) begin
          if (pin_up[l]) enter_state(l, ST_RELEASED, '0);
          else enter_state(l, ST_PRESSED, at_least_one(timing.hold_start_ticks));
        end
      end
      ST_PRESSED: begin
        if (ev == EVT_RELEASE) begin
          enter_state(l, ST_RELEASE_DB, at_least_one(timing.settle_ticks));
        end else if (ev == EVT_TIMER) begin
          if (lane_dir[l] == DIR_OFF) lane_dir[l] = DIR_DOWN;
          step_report.fade_step_mask[l] = 1'b1;
          if (lane_dir[l] == DIR_DOWN) step_report.fade_down_mask[l] = 1'b1;
          enter_state(l, ST_PRESSED, at_least_one(timing.repeat_ticks));
        end
      end
      ST_RELEASE_DB: begin
        if (ev == EVT_TIMER) begin
          if (!pin_up[l]) begin
            // pressed again before confirm: back to held, timer stays idle
            lane_state[l] = ST_PRESSED;
          end else if (lane_dir[l] == DIR_OFF) begin
            step_report.toggle_mask[l] = 1'b1;
            enter_state(l, ST_RELEASED, '0);
          end else begin
            enter_state(l, ST_WAIT_REPRESS, at_least_one(timing.repress_window_ticks));
          end
        end
      end
      ST_REPRESS_DB: begin
        if (ev == EVT_TIMER) begin
          if (pin_up[l]) begin
            enter_state(l, ST_RELEASED, '0);
          end else begin
            lane_dir[l] = (lane_dir[l] == DIR_DOWN) ? DIR_UP : DIR_DOWN;
            enter_state(l, ST_PRESSED, at_least_one(timing.repeat_ticks));
          end
        end
      end
      ST_WAIT_REPRESS: begin
        if (ev == EVT_TIMER) begin
          lane_state[l] = ST_RELEASED;
          lane_dir[l]   = DIR_OFF;
        end else if (ev == EVT_PRESS) begin
          enter_state(l, ST_REPRESS_DB, at_least_one(timing.settle_ticks));
        end
      end
      default: begin
        if (ev == EVT_PRESS) enter_state(l, ST_PRESS_DB, at_least_one(timing.settle_ticks));
      end
    endcase
  endfunction

  function automatic bthd_pkg::out_t predict_report(input bthd_pkg::in_t item);
    logic [PW-1:0] diff;
    step_report = '0;
    if (item.op == OP_SAMPLE) begin
      diff = item.pins ^ prev_pins;
      for (int l = 0; l < NB; l++) begin
        if (diff[l]) begin
          pin_up[l] = item.pins[l];
          lane_event(l, item.pins[l] ? EVT_RELEASE : EVT_PRESS);
        end
      end
      prev_pins = item.pins;
    end else begin
      for (int l = 0; l < NB; l++) begin
        if (lane_timer[l] != '0) begin
          lane_timer[l] = lane_timer[l] - 1'b1;
          if (lane_timer[l] == '0) lane_event(l, EVT_TIMER);
        end
      end
    end
    step_report.all_idle = 1'b1;
    for (int l = 0; l < NB; l++) begin
      if (lane_state[l] != ST_RELEASED) step_report.all_idle = 1'b0;
    end
    return step_report;
  endfunction

  function automatic void reset_mirror();
    timing.settle_ticks         = bthd_pkg::DEBOUNCE_RST;
    timing.hold_start_ticks     = bthd_pkg::HOLD_RST;
    timing.repeat_ticks         = bthd_pkg::REPEAT_RST;
    timing.repress_window_ticks = bthd_pkg::WINDOW_RST;
    for (int l = 0; l < NB; l++) begin
      lane_state[l] = ST_RELEASED;
      pin_up[l]     = 1'b1;
      lane_dir[l]   = DIR_OFF;
      lane_timer[l] = '0;
    end
    prev_pins = '1;
  endfunction

  function automatic bthd_pkg::in_t make_item(input logic op, input logic [PW-1:0] p);
    bthd_pkg::in_t item;
    item.op   = op;
    item.pins = p;
    return item;
  endfunction

  function automatic void check_field(input string name, input logic [PW-1:0] want,
                                      input logic [PW-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t unexpected result transfer: expected none actual %h", $time, out_data);
      end else begin
        want_report = pending_reports.pop_front();
        check_field("toggle_mask", want_report.toggle_mask, out_data.toggle_mask);
        check_field("fade_step_mask", want_report.fade_step_mask, out_data.fade_step_mask);
        check_field("fade_down_mask", want_report.fade_down_mask, out_data.fade_down_mask);
        check_field("all_idle", PW'(want_report.all_idle), PW'(out_data.all_idle));
      end
    end
  end

  // output side: random stalls, long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send_item(input bthd_pkg::in_t item);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_reports.push_back(predict_report(item));
  endtask

  task automatic sample(input logic [PW-1:0] p);
    send_item(make_item(OP_SAMPLE, p));
  endtask

  task automatic tick(input int n);
    repeat (n) send_item(make_item(OP_TICK, PW'($urandom)));
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input bthd_pkg::reg_e idx, input logic [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bthd_pkg::REG_DEBOUNCE: timing.settle_ticks         = val;
      bthd_pkg::REG_HOLD:     timing.hold_start_ticks     = val;
      bthd_pkg::REG_REPEAT:   timing.repeat_ticks         = val;
      default:                timing.repress_window_ticks = val;
    endcase
  endtask

  task automatic set_timing(input logic [CW-1:0] deb, input logic [CW-1:0] hold,
                            input logic [CW-1:0] rpt, input logic [CW-1:0] win);
    drain_reports();
    cfg_write(bthd_pkg::REG_DEBOUNCE, deb);
    cfg_write(bthd_pkg::REG_HOLD, hold);
    cfg_write(bthd_pkg::REG_REPEAT, rpt);
    cfg_write(bthd_pkg::REG_WINDOW, win);
    cfg_we <= 1'b0;
  endtask

  // mostly single-button presses and releases, with ticks and some pin noise
  task automatic run_random(input int count);
    logic [PW-1:0] cur;
    int            roll;
    cur = prev_pins;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 58) begin
        tick(1);
      end else if (roll < 93) begin
        cur[$urandom_range(PW - 1)] ^= 1'b1;
        sample(cur);
      end else begin
        cur = PW'($urandom);
        sample(cur);
      end
    end
  endtask

  task automatic test_directed();
    // all buttons tapped at reset timing
    sample(5'b00000);
    tick(1);
    sample(5'b11111);
    tick(1);
    set_timing(8'd1, 8'd2, 8'd1, 8'd2);
    // hold on button 1: two down steps, repress flips to up, window runs out
    sample(5'b11101);
    tick(4);
    sample(5'b11111);
    tick(1);
    sample(5'b11101);
    tick(2);
    sample(5'b11111);
    tick(3);
    // bounce on button 2 during press and release debounce
    sample(5'b11011);
    sample(5'b11111);
    sample(5'b11011);
    tick(1);
    sample(5'b11111);
    sample(5'b11011);
    tick(2);
    sample(5'b11111);
    tick(1);
  endtask

  task automatic test_timing_extremes();
    set_timing(8'd255, 8'd255, 8'd255, 8'd255);
    sample(5'b01111);
    tick(2 * 255);
    sample(5'b11111);
    tick(4);
    set_timing(8'd1, 8'd1, 8'd1, 8'd1);
    run_random(100);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      set_timing(CW'($urandom_range(1, 3)), CW'($urandom_range(1, 8)),
                 CW'($urandom_range(1, 4)), CW'($urandom_range(1, 8)));
      idle_pct = (ph == 2) ? 0 : IDLE_PCT;
      run_random(100);
    end
    idle_pct = IDLE_PCT;
    set_timing(8'd2, 8'd12, 8'd6, 8'd10);
    run_random(150);
  endtask

  task automatic test_backpressure();
    set_timing(8'd1, 8'd3, 8'd2, 8'd4);
    hold_out_req = 1'b1;
    run_random(40);
    drain_reports();
    run_random(40);
  endtask

  initial begin
    reset_mirror();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_timing_extremes();
    test_random();
    test_backpressure();
    drain_reports();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_button_tap_hold_dimmer_fsm passed");
    end else begin
      $display("tb_button_tap_hold_dimmer_fsm failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_button_tap_hold_dimmer_fsm failed");
    $finish;
  end

endmodule
